@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_IMPL(label, 1'b1, !(cond), msg)

`endif

@@ rtl/sfrl_pkg.sv @@
package sfrl_pkg;

  // table size default
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_LIMIT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 8'd1;

  // register reset values
  localparam logic [31:0] SYN_LIMIT_RST     = 32'd100;
  localparam logic [63:0] WINDOW_LENGTH_RST = 64'd1_000_000_000;

  // header constants
  localparam logic [15:0] ETHER_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [16:0] ETH_HDR_BYTES = 17'd14;
  localparam logic [16:0] IP_MIN_BYTES  = 17'd20;
  localparam logic [16:0] TCP_HDR_BYTES = 17'd20;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [3:0]  ip_header_words;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_rst;
    logic [31:0] source_addr;
    logic [63:0] time_ns;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic        was_counted;
    logic [31:0] window_count;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [63:0] window_start;
    logic [31:0] syn_count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_EVAL,
    ST_WRITE
  } state_t;

  // bounds, ethertype, protocol and flag checks for a countable syn
  function automatic logic qualifies(input in_item_t item);
    logic [16:0] len;
    logic [16:0] need;
    len  = {1'b0, item.frame_length};
    need = ETH_HDR_BYTES + {11'd0, item.ip_header_words, 2'b00} + TCP_HDR_BYTES;
    return (len >= ETH_HDR_BYTES) && (len >= ETH_HDR_BYTES + IP_MIN_BYTES) &&
           (len >= need) && (item.ether_type == ETHER_IPV4) &&
           (item.ip_proto == PROTO_TCP) && item.flag_syn && !item.flag_ack &&
           !item.flag_rst;
  endfunction

endpackage

@@ rtl/sfrl_ram.sv @@
module sfrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sfrl_index.sv @@
module sfrl_index #(
  parameter int unsigned TABLE_ENTRIES = sfrl_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      addr,
  output logic             done,
  output logic [IDX_W-1:0] idx
);

  // addr mod TABLE_ENTRIES by reciprocal multiply, quotient low by at most one
  localparam int unsigned LOG_N = $clog2(TABLE_ENTRIES);
  localparam logic [64:0] MOD_NUM = 65'd1 << (32 + LOG_N);
  localparam logic [32:0] MOD_MUL = 33'(MOD_NUM / 65'(TABLE_ENTRIES));
  localparam logic [IDX_W:0] MOD_N = (IDX_W + 1)'(TABLE_ENTRIES);

  logic             v1_r, v2_r, v3_r;
  logic [31:0]      addr1_r, addr2_r;
  logic [31:0]      q_r;
  logic [31:0]      p_r;
  logic [IDX_W-1:0] idx_r;
  logic [64:0]      prod;
  logic [48:0]      p_full;
  logic [31:0]      diff;
  logic [IDX_W:0]   rem;
  logic [IDX_W:0]   rem_fix;

  // stage arithmetic
  always_comb begin
    prod    = {32'd0, addr} * {32'd0, MOD_MUL};
    p_full  = {17'd0, q_r} * 49'(TABLE_ENTRIES);
    diff    = addr2_r - p_r;
    rem     = diff[IDX_W:0];
    rem_fix = (rem >= MOD_N) ? rem - MOD_N : rem;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // quotient, product and corrected remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r     <= 32'(prod >> (32 + LOG_N));
      addr1_r <= addr;
    end
    if (v1_r) begin
      p_r     <= p_full[31:0];
      addr2_r <= addr1_r;
    end
    if (v2_r) begin
      idx_r <= rem_fix[IDX_W-1:0];
    end
  end

  assign done = v3_r;
  assign idx  = idx_r;

endmodule

@@ rtl/syn_flood_rate_limiter_unit.sv @@
// counted syn: input accept, the 3-stage index modulo, the table read, the entry
// update and the write back with the result, which waits while the output is
// stalled; the next item is accepted only after the return to idle
// other packets: no index or table access, straight to the result, then back to idle
// after reset the table is cleared one entry a cycle until the last entry is written,
// during which no item is accepted; config writes are always taken
`include "assert_macros.svh"

module syn_flood_rate_limiter_unit #(
  parameter int unsigned TABLE_ENTRIES = sfrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfrl_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfrl_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_wdata
);

  import sfrl_pkg::*;

  localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic             qual_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] clr_cnt_r;
  entry_t           ent_r;
  logic             hit_r;
  logic             inwin_r;
  logic [31:0]      syn_limit_r;
  logic [63:0]      window_length_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic             in_accept;
  logic             in_qual;
  logic             idx_start;
  logic             idx_done;
  logic [IDX_W-1:0] idx_val;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_ent;
  entry_t           new_ent;
  logic             new_verdict;
  logic [31:0]      cnt_inc;
  logic [63:0]      elapsed;
  logic             out_free;
  logic             out_load;

  // modulo index unit
  sfrl_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_index (
    .clk(clk),
    .rst_n(rst_n),
    .start(idx_start),
    .addr(in_item.source_addr),
    .done(idx_done),
    .idx(idx_val)
  );

  // per-source table
  sfrl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES),
    .AW(IDX_W)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(idx_val),
    .rdata(ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // window test on the freshly read entry
  assign elapsed = item_r.time_ns - rd_ent.window_start;

  // entry update and verdict
  always_comb begin
    cnt_inc = (ent_r.syn_count == COUNT_MAX) ? COUNT_MAX : ent_r.syn_count + 32'd1;
    if (hit_r && inwin_r) begin
      new_ent           = ent_r;
      new_ent.syn_count = cnt_inc;
      new_verdict       = (cnt_inc > syn_limit_r);
    end else begin
      new_ent.valid        = 1'b1;
      new_ent.tag          = item_r.source_addr;
      new_ent.window_start = item_r.time_ns;
      new_ent.syn_count    = 32'd1;
      new_verdict          = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_nxt = in_qual ? ST_INDEX : ST_WRITE;
      end
      ST_INDEX: begin
        if (idx_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    in_accept = in_valid && in_ready;
    in_qual   = qualifies(in_item);
    idx_start = in_accept && in_qual;
    out_free  = !out_valid_r || out_ready;
    out_load  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = new_ent;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_INDEX: begin
        ram_re = idx_done;
      end
      ST_WRITE: begin
        out_load = out_free;
        ram_we   = out_free && qual_r;
      end
      ST_IDLE, ST_EVAL: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syn_limit_r     <= SYN_LIMIT_RST;
      window_length_r <= WINDOW_LENGTH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SYN_LIMIT) begin
        syn_limit_r <= cfg_wdata[31:0];
      end else if (cfg_index == CFG_WINDOW_LENGTH) begin
        window_length_r <= cfg_wdata;
      end
    end
  end

  // item payload and table read results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_item;
      qual_r <= in_qual;
    end
    if (state_r == ST_INDEX && idx_done) begin
      idx_r <= idx_val;
    end
    if (state_r == ST_EVAL) begin
      ent_r   <= rd_ent;
      hit_r   <= rd_ent.valid && (rd_ent.tag == item_r.source_addr);
      inwin_r <= (elapsed < window_length_r);
    end
    if (out_load) begin
      out_r.verdict      <= qual_r && new_verdict;
      out_r.was_counted  <= qual_r;
      out_r.window_count <= qual_r ? new_ent.syn_count : 32'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  `ASSERT_IMPL(a_index_done_waited, idx_done, state_r == ST_INDEX,
               "index result with no item waiting")
  `ASSERT_IMPL(a_drop_over_limit, out_valid_r && out_r.verdict,
               out_r.was_counted && (out_r.window_count > syn_limit_r),
               "drop without count above limit")
  `ASSERT_IMPL(a_counted_nonzero, out_valid_r && out_r.was_counted,
               out_r.window_count != 32'd0, "counted item with zero count")
  `ASSERT_NEVER(a_table_rw_overlap, ram_we && ram_re, "table read and write in one cycle")

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrl_pkg::*;

  localparam int unsigned TBL_SIZE = TABLE_ENTRIES_DEF;
  localparam int unsigned ETH_BYTES = 14;
  localparam int unsigned IP_BYTES = 20;
  localparam int unsigned TCP_BYTES = 20;
  localparam int unsigned SRC_DISTINCT = 4;
  localparam int unsigned SRC_POOL = 6;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = 8'hFF;
  localparam logic [15:0] ETHER_IPV6 = 16'h86DD;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // per-source syn window table and the verdicts it predicts
  class syn_window_tracker;
    bit entry_used [TBL_SIZE];
    bit [31:0] entry_src [TBL_SIZE];
    bit [63:0] entry_start [TBL_SIZE];
    bit [31:0] entry_count [TBL_SIZE];
    bit [31:0] syn_limit;
    bit [63:0] window_ns;
    out_item_t expected_verdicts[$];
    int unsigned errors;

    function new();
      syn_limit = SYN_LIMIT_RST;
      window_ns = WINDOW_LENGTH_RST;
      errors = 0;
      foreach (entry_used[i]) entry_used[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [63:0] data);
      case (index)
        CFG_SYN_LIMIT: syn_limit = data[31:0];
        CFG_WINDOW_LENGTH: window_ns = data;
        default: ;
      endcase
    endfunction

    // headers fit, ipv4, tcp, and a bare syn
    function bit is_counted_syn(in_item_t pkt);
      int unsigned len;
      int unsigned tcp_end;
      len = 32'(pkt.frame_length);
      tcp_end = ETH_BYTES + 32'(pkt.ip_header_words) * 4 + TCP_BYTES;
      return len >= ETH_BYTES + IP_BYTES && len >= tcp_end &&
             pkt.ether_type == ETHER_IPV4 && pkt.ip_proto == PROTO_TCP &&
             pkt.flag_syn && !pkt.flag_ack && !pkt.flag_rst;
    endfunction

    function void note_packet(in_item_t pkt);
      out_item_t exp;
      int unsigned slot;
      exp = '0;
      if (is_counted_syn(pkt)) begin
        slot = pkt.source_addr % TBL_SIZE;
        // same source inside its window: count on, drop past the limit
        if (entry_used[slot] && entry_src[slot] == pkt.source_addr &&
            pkt.time_ns - entry_start[slot] < window_ns) begin
          if (entry_count[slot] != COUNT_MAX) entry_count[slot]++;
          exp.verdict = entry_count[slot] > syn_limit;
        end else begin
          entry_used[slot] = 1'b1;
          entry_src[slot] = pkt.source_addr;
          entry_start[slot] = pkt.time_ns;
          entry_count[slot] = 1;
        end
        exp.was_counted = 1'b1;
        exp.window_count = entry_count[slot];
      end
      expected_verdicts.push_back(exp);
    endfunction

    function void report_field(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t exp;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with no packet waiting, expected none actual %0b/%0b/%0d",
                 $time, got.verdict, got.was_counted, got.window_count);
      end else begin
        exp = expected_verdicts.pop_front();
        if (got.verdict !== exp.verdict)
          report_field("verdict", 64'(exp.verdict), 64'(got.verdict));
        if (got.was_counted !== exp.was_counted)
          report_field("was_counted", 64'(exp.was_counted), 64'(got.was_counted));
        if (got.window_count !== exp.window_count)
          report_field("window_count", 64'(exp.window_count), 64'(got.window_count));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  idle_mode_t idle_mode = IDLE_NONE;
  syn_window_tracker tracker;
  logic [31:0] src_pool [SRC_POOL];
  logic [63:0] sim_clock_ns = '0;
  int unsigned stall_cycles = 0;

  syn_flood_rate_limiter_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= $urandom_range(99) >= 57;
      IDLE_BOTH: out_ready <= $urandom_range(99) >= 32;
      default: out_ready <= 1'b1;
    endcase
  end

  // predict on every accepted item, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_packet(in_item);
      if (out_valid && out_ready) tracker.check_verdict(out_item);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("syn_flood_rate_limiter_unit test failed");
      $finish;
    end
  end

  // sender gaps, called at a falling edge
  task automatic sender_gap();
    int unsigned pct;
    pct = (idle_mode == IDLE_SEND) ? 57 : (idle_mode == IDLE_BOTH) ? 32 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_packet(in_item_t pkt);
    sender_gap();
    in_valid = 1'b1;
    in_item = pkt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // every verdict back, then let the pipeline settle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t syn_packet(logic [31:0] addr, logic [63:0] t);
    in_item_t pkt;
    pkt = '0;
    pkt.frame_length = 16'd60;
    pkt.ether_type = ETHER_IPV4;
    pkt.ip_proto = PROTO_TCP;
    pkt.ip_header_words = 4'd5;
    pkt.flag_syn = 1'b1;
    pkt.source_addr = addr;
    pkt.time_ns = t;
    return pkt;
  endfunction

  // mostly well-formed syns from a few sources, some near misses, some noise
  function automatic in_item_t random_packet(int unsigned step_max);
    in_item_t pkt;
    int unsigned roll;
    int unsigned need;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 3) sim_clock_ns = {$urandom, $urandom};
    else sim_clock_ns += 64'($urandom_range(step_max));
    pkt = '0;
    pkt.ip_header_words = 4'($urandom_range(15));
    need = ETH_BYTES + 32'(pkt.ip_header_words) * 4 + TCP_BYTES;
    case ($urandom_range(3))
      0: pkt.frame_length = 16'(need);
      1: pkt.frame_length = 16'hFFFF;
      default: pkt.frame_length = 16'(need + $urandom_range(1500));
    endcase
    pkt.ether_type = ETHER_IPV4;
    pkt.ip_proto = PROTO_TCP;
    pkt.flag_syn = 1'b1;
    pkt.source_addr = ($urandom_range(19) == 0) ? $urandom : src_pool[$urandom_range(SRC_POOL-1)];
    pkt.time_ns = sim_clock_ns;
    if (roll >= 85) begin
      pkt.frame_length = 16'($urandom_range(16'hFFFF));
      pkt.ether_type = 16'($urandom_range(16'hFFFF));
      pkt.ip_proto = 8'($urandom_range(255));
      pkt.ip_header_words = 4'($urandom_range(15));
      pkt.flag_syn = 1'($urandom_range(1));
      pkt.flag_ack = 1'($urandom_range(1));
      pkt.flag_rst = 1'($urandom_range(1));
      pkt.source_addr = $urandom;
      pkt.time_ns = {$urandom, $urandom};
    end else if (roll >= 70) begin
      case ($urandom_range(4))
        0: pkt.frame_length = 16'($urandom_range(need - 1));
        1: pkt.ether_type = 16'($urandom_range(16'hFFFF));
        2: pkt.ip_proto = 8'($urandom_range(255));
        3: pkt.flag_ack = 1'b1;
        default: begin
          pkt.flag_syn = 1'($urandom_range(1));
          pkt.flag_rst = 1'b1;
        end
      endcase
    end
    return pkt;
  endfunction

  task automatic run_phase(bit write_cfg, logic [31:0] limit, logic [63:0] window,
                           int unsigned step_max, idle_mode_t mode);
    wait_drained();
    if (write_cfg) begin
      cfg_write(CFG_SYN_LIMIT, 64'(limit));
      cfg_write(CFG_WINDOW_LENGTH, window);
    end
    // fresh sources, two of them sharing a table slot with another
    for (int i = 0; i < SRC_DISTINCT; i++) src_pool[i] = $urandom;
    for (int i = SRC_DISTINCT; i < SRC_POOL; i++) begin
      src_pool[i] = {src_pool[i-SRC_DISTINCT][31:12] + 20'($urandom_range(1, 1000)),
                     src_pool[i-SRC_DISTINCT][11:0]};
    end
    idle_mode = mode;
    repeat (ITEMS_PER_PHASE) send_packet(random_packet(step_max));
  endtask

  // header bounds, each failed check, window edges, slot aliasing, time wrap
  task automatic directed_packets();
    in_item_t pkt;
    logic [31:0] src_a;
    logic [31:0] src_b;
    logic [31:0] src_c;
    wait_drained();
    idle_mode = IDLE_NONE;
    cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
    cfg_write(CFG_IDX_TOP, '1);
    cfg_write(CFG_SYN_LIMIT, 64'd1);
    cfg_write(CFG_WINDOW_LENGTH, 64'd1000);
    src_a = $urandom;
    src_b = {src_a[31:12] + 20'd1, src_a[11:0]};
    src_c = {20'($urandom_range(32'hFFFFF)), src_a[11:0] ^ 12'h800};
    pkt = syn_packet(src_a, 64'd100);
    pkt.frame_length = 16'd0;
    send_packet(pkt);
    pkt.frame_length = 16'd13;
    send_packet(pkt);
    pkt = syn_packet(src_a, 64'd100);
    pkt.ether_type = ETHER_IPV6;
    send_packet(pkt);
    pkt = syn_packet(src_a, 64'd100);
    pkt.ip_header_words = 4'd0;
    pkt.frame_length = 16'd33;
    send_packet(pkt);
    pkt = syn_packet(src_a, 64'd100);
    pkt.ip_proto = PROTO_UDP;
    send_packet(pkt);
    pkt = syn_packet(src_a, 64'd100);
    pkt.ip_header_words = 4'd15;
    pkt.frame_length = 16'd93;
    send_packet(pkt);
    pkt.frame_length = 16'd94;
    send_packet(pkt);
    // short ihl, tcp header overlapping the ip header
    pkt = syn_packet(src_a, 64'd200);
    pkt.ip_header_words = 4'd0;
    pkt.frame_length = 16'd34;
    send_packet(pkt);
    pkt = syn_packet(src_a, 64'd300);
    pkt.flag_syn = 1'b0;
    send_packet(pkt);
    pkt.flag_syn = 1'b1;
    pkt.flag_ack = 1'b1;
    send_packet(pkt);
    pkt.flag_ack = 1'b0;
    pkt.flag_rst = 1'b1;
    send_packet(pkt);
    // exactly one window later, then just inside the new window
    send_packet(syn_packet(src_a, 64'd1100));
    send_packet(syn_packet(src_a, 64'd2099));
    send_packet(syn_packet(src_a, 64'd2099));
    send_packet(syn_packet(src_b, 64'd2100));
    send_packet(syn_packet(src_a, 64'd2101));
    // time wrapping past zero, then a time before the window start
    send_packet(syn_packet(src_c, 64'hFFFF_FFFF_FFFF_FFF6));
    send_packet(syn_packet(src_c, 64'd5));
    send_packet(syn_packet(src_c, 64'hFFFF_FFFF_FFFF_FFEC));
    pkt = syn_packet('1, '1);
    pkt.frame_length = 16'hFFFF;
    send_packet(pkt);
    pkt.ether_type = 16'hFFFF;
    send_packet(pkt);
    send_packet(syn_packet('0, '0));
  endtask

  initial begin
    tracker = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    run_phase(1'b0, '0, '0, 1000, IDLE_NONE);
    directed_packets();
    run_phase(1'b1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1000, IDLE_SEND);
    run_phase(1'b1, 32'd3, 64'd100, 10, IDLE_RECV);
    run_phase(1'b1, 32'hFFFF_FFFF, 64'd1, 1, IDLE_BOTH);
    run_phase(1'b1, 32'd5, 64'd0, 50, IDLE_NONE);
    run_phase(1'b1, 32'd1, 64'd40, 8, IDLE_BOTH);
    run_phase(1'b1, 32'd10, 64'd1000, 20, IDLE_SEND);
    wait_drained();

    if (tracker.errors == 0 && tracker.expected_verdicts.size() == 0) begin
      $display("syn_flood_rate_limiter_unit test passed");
    end else begin
      $display("syn_flood_rate_limiter_unit test failed");
    end
    $finish;
  end

endmodule
